// ===== design/rcocs_pkg.sv =====
`timescale 1ns / 1ps

package rcocs_pkg;

	localparam int TEMP_WIDTH_DEFAULT = 16;
	localparam int KIND_WIDTH = 3;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = 8;
	localparam int LIMIT_WIDTH = 8;
	localparam int COUNT_WIDTH = 8;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic [KIND_WIDTH-1:0] KIND_TEMP_READY = 3'd0;
	localparam logic [KIND_WIDTH-1:0] KIND_CAL_DONE   = 3'd1;
	localparam logic [KIND_WIDTH-1:0] KIND_TIMEOUT    = 3'd2;
	localparam logic [KIND_WIDTH-1:0] KIND_HF_STARTED = 3'd3;
	localparam logic [KIND_WIDTH-1:0] KIND_LF_STARTED = 3'd4;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAL_ENABLE    = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_XTAL_SELECTED = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DELTA_LIMIT   = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUTS      = 2'd3;

	localparam logic [LIMIT_WIDTH-1:0] DELTA_LIMIT_RESET = 8'd2;
	localparam logic [COUNT_WIDTH-1:0] TIMEOUTS_RESET    = 8'd2;

	typedef struct packed {
		logic start_temp;
		logic stop_temp;
		logic start_calibration;
		logic start_hfxo;
		logic stop_hfxo;
		logic start_cal_timer;
		logic stop_lfclk;
		logic lfclk_available;
	} res_t;

endpackage

// ===== design/rcocs_if.sv =====
`timescale 1ns / 1ps

interface rcocs_evt_if import rcocs_pkg::*; #(
	parameter int TEMP_WIDTH = TEMP_WIDTH_DEFAULT
);
	logic                         valid;
	logic                         ready;
	logic [KIND_WIDTH-1:0]        kind;
	logic signed [TEMP_WIDTH-1:0] temperature;
	logic                         hfxo_running;
	logic                         lf_requested;

	modport source (output valid, kind, temperature, hfxo_running, lf_requested, input ready);
	modport sink (input valid, kind, temperature, hfxo_running, lf_requested, output ready);
endinterface

interface rcocs_res_if;
	logic valid;
	logic ready;
	logic start_temp;
	logic stop_temp;
	logic start_calibration;
	logic start_hfxo;
	logic stop_hfxo;
	logic start_cal_timer;
	logic stop_lfclk;
	logic lfclk_available;

	modport source (output valid, start_temp, stop_temp, start_calibration, start_hfxo,
		stop_hfxo, start_cal_timer, stop_lfclk, lfclk_available, input ready);
	modport sink (input valid, start_temp, stop_temp, start_calibration, start_hfxo,
		stop_hfxo, start_cal_timer, stop_lfclk, lfclk_available, output ready);
endinterface

// ===== design/rc_osc_calibration_sequencer_top.sv =====
`timescale 1ns / 1ps

// RC oscillator calibration sequencer.
// Events enter on the evt channel (valid/ready); each accepted transaction
// produces exactly one transaction of task strobes on the res channel.
// The cfg port writes the four registers (enable, crystal select, delta
// limit, timeouts per measure) with cfg_we/cfg_index/cfg_data; write only
// while no event is in flight.
// An event is registered in the input stage on acceptance and its strobes
// are registered in the result stage when that stage advances, which waits
// while the receiver has not taken the previous result. Throughput is one
// event per cycle while the receiver takes every result, set by the single
// input register and the result register; the flag update is one short pass
// of logic plus one subtract-and-compare on the temperature.
// When the receiver stalls, the result register holds its strobes and one
// more event can still be taken into the input register; after that ready
// drops until the result is taken.
// Reset (arst_n low, asynchronous) clears all flags, the timeout count, the
// stored temperatures and both stages, and loads the register defaults
// (calibration off, crystal not selected, limit 2, two timeouts).
module rc_osc_calibration_sequencer_top import rcocs_pkg::*; #(
	parameter int TEMP_WIDTH = TEMP_WIDTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rcocs_evt_if.sink                  evt,
	rcocs_res_if.source                res,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	// Configuration registers
	logic                   cal_enable_q;
	logic                   xtal_selected_q;
	logic [LIMIT_WIDTH-1:0] delta_limit_q;
	logic [COUNT_WIDTH-1:0] timeouts_q;

	// Sequencer state
	logic                         cal_requested_q;
	logic                         cal_busy_q;
	logic                         temp_busy_q;
	logic                         cal_complete_q;
	logic [COUNT_WIDTH-1:0]       timeout_count_q;
	logic signed [TEMP_WIDTH-1:0] last_cal_temp_q;
	logic signed [TEMP_WIDTH-1:0] current_temp_q;

	// Input stage
	logic                         valid_s1;
	logic [KIND_WIDTH-1:0]        kind_s1;
	logic signed [TEMP_WIDTH-1:0] temp_s1;
	logic                         hfxo_s1;
	logic                         lfreq_s1;

	// Result stage
	logic res_valid_s2;
	res_t res_s2;

	logic advance;

	assign advance   = valid_s1 && (!res_valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_enable_q    <= 1'b0;
			xtal_selected_q <= 1'b0;
			delta_limit_q   <= DELTA_LIMIT_RESET;
			timeouts_q      <= TIMEOUTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAL_ENABLE:    cal_enable_q    <= cfg_data[0];
				CFG_XTAL_SELECTED: xtal_selected_q <= cfg_data[0];
				CFG_DELTA_LIMIT:   delta_limit_q   <= cfg_data[LIMIT_WIDTH-1:0];
				CFG_TIMEOUTS:      timeouts_q      <= cfg_data[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1  <= evt.kind;
			temp_s1  <= evt.temperature;
			hfxo_s1  <= evt.hfxo_running;
			lfreq_s1 <= evt.lf_requested;
		end
	end

	// Temperature change since the last calibration, one bit wider so the
	// difference and its magnitude never overflow.
	logic signed [TEMP_WIDTH:0] diff;
	logic        [TEMP_WIDTH:0] diff_abs;
	logic                       delta_exceeded;

	assign diff     = {temp_s1[TEMP_WIDTH-1], temp_s1}
	                - {last_cal_temp_q[TEMP_WIDTH-1], last_cal_temp_q};
	assign diff_abs = diff[TEMP_WIDTH] ? (TEMP_WIDTH+1)'(-diff) : (TEMP_WIDTH+1)'(diff);
	assign delta_exceeded = diff_abs > {{(TEMP_WIDTH+1-LIMIT_WIDTH){1'b0}}, delta_limit_q};

	logic                         n_pending;
	logic                         n_cal_busy;
	logic                         n_temp_busy;
	logic                         n_complete;
	logic [COUNT_WIDTH-1:0]       n_count;
	logic signed [TEMP_WIDTH-1:0] n_last;
	logic signed [TEMP_WIDTH-1:0] n_current;
	res_t                         res_c;
	logic                         hf_try;
	logic                         lf_try;
	logic [COUNT_WIDTH-1:0]       count_inc;

	assign count_inc = (timeout_count_q != COUNT_MAX) ? timeout_count_q + 1'b1 : timeout_count_q;

	// The steps below are evaluated in order, each seeing the flags left by
	// the step before, as the event handling is defined.
	always_comb begin
		n_pending   = cal_requested_q;
		n_cal_busy  = cal_busy_q;
		n_temp_busy = temp_busy_q;
		n_complete  = cal_complete_q;
		n_count     = timeout_count_q;
		n_last      = last_cal_temp_q;
		n_current   = current_temp_q;
		res_c       = '0;
		hf_try      = 1'b0;
		lf_try      = 1'b0;

		case (kind_s1)
			KIND_TEMP_READY: begin
				n_temp_busy = 1'b0;
				if (!n_cal_busy) begin
					n_current       = temp_s1;
					res_c.stop_temp = 1'b1;
					if (delta_exceeded && !n_pending) begin
						n_pending = 1'b1;
						if (hfxo_s1) begin
							if (cal_enable_q && !n_cal_busy && !n_temp_busy) begin
								n_cal_busy              = 1'b1;
								n_temp_busy             = 1'b1;
								res_c.start_temp        = 1'b1;
								res_c.start_calibration = 1'b1;
							end
						end else begin
							res_c.start_hfxo = 1'b1;
						end
					end else begin
						n_count = '0;
					end
				end
			end
			KIND_CAL_DONE: begin
				n_last     = current_temp_q;
				n_complete = cal_enable_q;
				n_cal_busy = 1'b0;
				n_pending  = 1'b0;
				n_count    = '0;
				hf_try     = 1'b1;
				lf_try     = 1'b1;
			end
			KIND_TIMEOUT: begin
				n_count = count_inc;
				if (count_inc >= timeouts_q && !n_temp_busy) begin
					n_temp_busy      = 1'b1;
					res_c.start_temp = 1'b1;
				end
				res_c.start_cal_timer = cal_enable_q;
			end
			KIND_HF_STARTED: hf_try = 1'b1;
			KIND_LF_STARTED: lf_try = 1'b1;
			default: ;
		endcase

		if (hf_try && hfxo_s1) begin
			if (cal_enable_q && n_pending && !n_cal_busy && !n_temp_busy) begin
				n_cal_busy              = 1'b1;
				n_temp_busy             = 1'b1;
				res_c.start_temp        = 1'b1;
				res_c.start_calibration = 1'b1;
			end
			if (!xtal_selected_q && !(n_pending && cal_enable_q)) begin
				res_c.stop_hfxo = 1'b1;
			end
		end

		if (lf_try) begin
			if (lfreq_s1) begin
				if (cal_enable_q && !n_complete) begin
					n_pending = 1'b1;
					if (hfxo_s1) begin
						if (!n_cal_busy && !n_temp_busy) begin
							n_cal_busy              = 1'b1;
							n_temp_busy             = 1'b1;
							res_c.start_temp        = 1'b1;
							res_c.start_calibration = 1'b1;
						end
					end else begin
						res_c.start_hfxo = 1'b1;
					end
					res_c.start_cal_timer = 1'b1;
				end
				res_c.lfclk_available = 1'b1;
			end else begin
				n_complete       = 1'b0;
				res_c.stop_lfclk = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_requested_q <= 1'b0;
			cal_busy_q      <= 1'b0;
			temp_busy_q     <= 1'b0;
			cal_complete_q  <= 1'b0;
			timeout_count_q <= '0;
			last_cal_temp_q <= '0;
			current_temp_q  <= '0;
		end else if (advance) begin
			cal_requested_q <= n_pending;
			cal_busy_q      <= n_cal_busy;
			temp_busy_q     <= n_temp_busy;
			cal_complete_q  <= n_complete;
			timeout_count_q <= n_count;
			last_cal_temp_q <= n_last;
			current_temp_q  <= n_current;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign res.valid             = res_valid_s2;
	assign res.start_temp        = res_s2.start_temp;
	assign res.stop_temp         = res_s2.stop_temp;
	assign res.start_calibration = res_s2.start_calibration;
	assign res.start_hfxo        = res_s2.start_hfxo;
	assign res.stop_hfxo         = res_s2.stop_hfxo;
	assign res.start_cal_timer   = res_s2.start_cal_timer;
	assign res.stop_lfclk        = res_s2.stop_lfclk;
	assign res.lfclk_available   = res_s2.lfclk_available;

	// A calibration always starts together with a temperature measurement.
	a_cal_with_temp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.start_calibration |-> res_s2.start_temp)
		else $error("calibration started without a temperature measurement");

	// Starting the crystal and starting a calibration exclude each other.
	a_hfxo_vs_cal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> !(res_s2.start_hfxo && res_s2.start_calibration))
		else $error("crystal start and calibration start in one transaction");

	// A started calibration leaves both busy flags set.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_c.start_calibration |=> cal_busy_q && temp_busy_q)
		else $error("busy flags not set after calibration start");

	// A stalled event in the input stage keeps its contents and the state.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(cal_requested_q))
		else $error("input stage or state changed while stalled");

endmodule
